>>> sv/ptq_pkg.sv
// Shared types, codes and constants of the periodic timer queue.
package ptq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int TIME_W  = 63;
    localparam int DELAY_W = 32;
    localparam int ID_W    = 4;
    localparam int STAT_W  = 3;
    localparam int IN_W    = 104;
    localparam int OUT_W   = 72;

    localparam logic [1:0] OP_START    = 2'd0;
    localparam logic [1:0] OP_STOP     = 2'd1;
    localparam logic [1:0] OP_DISPATCH = 2'd2;

    localparam logic [STAT_W-1:0] ST_STARTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_STOPPED = 3'd1;
    localparam logic [STAT_W-1:0] ST_FIRED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_WAITING = 3'd3;
    localparam logic [STAT_W-1:0] ST_NONE    = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd5;
    localparam logic [STAT_W-1:0] ST_BADID   = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_PRUNE,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic              latch_in;
        logic              alloc;
        logic              mark_stop;
        logic              set_time;
        logic              prune_head;
        logic              fire;
        logic              scan_step;
        logic              place;
        logic              out_load;
        logic [STAT_W-1:0] out_code;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       free_found;
        logic       count_zero;
        logic       count_full;
        logic       head_stopped;
        logic       head_late;
        logic       scan_done;
        logic       id_ok;
        logic       out_busy;
    } stat_t;

endpackage

>>> sv/ptq_ctrl.sv
// Controller state machine of the periodic timer queue.
module ptq_ctrl
    import ptq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE) && !st.out_busy;
    assign accept   = in_ready && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (st.op == OP_START && st.free_found && !st.count_full)
                begin
                    state_next = S_SCAN;
                end
                else if (st.op == OP_DISPATCH)
                begin
                    state_next = S_PRUNE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PRUNE:
            begin
                if (st.count_zero)
                begin
                    state_next = S_IDLE;
                end
                else if (st.head_stopped)
                begin
                    state_next = S_PRUNE;
                end
                else if (st.head_late)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (st.scan_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.latch_in = accept;
            end
            S_DECODE:
            begin
                case (st.op)
                    OP_START:
                    begin
                        if (st.free_found && !st.count_full)
                        begin
                            cmd.alloc = 1'b1;
                        end
                        else
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_code = ST_FULL;
                        end
                    end
                    OP_STOP:
                    begin
                        cmd.out_load  = 1'b1;
                        cmd.mark_stop = st.id_ok;
                        cmd.out_code  = st.id_ok ? ST_STOPPED : ST_BADID;
                    end
                    OP_DISPATCH:
                    begin
                        cmd.set_time = 1'b1;
                    end
                    default:
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_code = ST_BADID;
                    end
                endcase
            end
            S_PRUNE:
            begin
                if (st.count_zero)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_code = ST_NONE;
                end
                else if (st.head_stopped)
                begin
                    cmd.prune_head = 1'b1;
                end
                else if (st.head_late)
                begin
                    cmd.fire = 1'b1;
                end
                else
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_code = ST_WAITING;
                end
            end
            S_SCAN:
            begin
                if (st.scan_done)
                begin
                    cmd.place    = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_code = (st.op == OP_START) ? ST_STARTED : ST_FIRED;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/ptq_dp.sv
// Datapath of the periodic timer queue: slot tables, ordered list and result register.
module ptq_dp
    import ptq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IN_W-1:0]  in_data,
    input  cmd_t             cmd,
    output stat_t            st,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data
);

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (SW > ID_W) ? SW : ID_W;

    logic [CAPACITY-1:0] in_use_reg;
    logic [CAPACITY-1:0] stopped_reg;
    logic [DELAY_W-1:0]  period_reg   [CAPACITY];
    logic [TIME_W-1:0]   deadline_reg [CAPACITY];
    logic [SW-1:0]       order_reg    [CAPACITY];
    logic [CW-1:0]       count_reg;
    logic [TIME_W-1:0]   last_time_reg;

    logic [1:0]          op_reg;
    logic [DELAY_W-1:0]  delay_reg;
    logic [ID_W-1:0]     id_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [SW-1:0]       slot_reg;
    logic [TIME_W-1:0]   d_reg;
    logic [CW-1:0]       pos_reg;

    logic                out_valid_reg;
    logic [STAT_W-1:0]   out_status_reg;
    logic [ID_W-1:0]     out_rid_reg;
    logic [TIME_W-1:0]   out_wait_reg;

    logic [SW-1:0]       free_slot;
    logic                free_found;
    logic [SW-1:0]       rd_slot;
    logic [TIME_W-1:0]   rd_deadline;
    logic [DELAY_W-1:0]  rd_period;
    logic [IW-1:0]       id_ext;
    logic [TIME_W:0]     start_sum;
    logic [TIME_W:0]     fire_sum;
    logic [TIME_W-1:0]   start_dl;
    logic [TIME_W-1:0]   fire_dl;

    always_comb
    begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_slot  = SW'(i);
                free_found = 1'b1;
            end
        end
    end

    // The list position walks from the head, so one read port serves both
    // the head checks and the insertion scan.
    assign rd_slot     = order_reg[pos_reg[SW-1:0]];
    assign rd_deadline = deadline_reg[rd_slot];
    assign rd_period   = period_reg[rd_slot];
    assign id_ext      = IW'(id_reg);

    assign start_sum = {1'b0, last_time_reg} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay_reg};
    assign fire_sum  = {1'b0, rd_deadline} + {{(TIME_W + 1 - DELAY_W){1'b0}}, rd_period};
    assign start_dl  = start_sum[TIME_W] ? {TIME_W{1'b1}} : start_sum[TIME_W-1:0];
    assign fire_dl   = fire_sum[TIME_W] ? {TIME_W{1'b1}} : fire_sum[TIME_W-1:0];

    assign st.op           = op_reg;
    assign st.free_found   = free_found;
    assign st.count_zero   = (count_reg == '0);
    assign st.count_full   = (count_reg >= CW'(CAPACITY));
    assign st.head_stopped = stopped_reg[rd_slot];
    assign st.head_late    = (rd_deadline < now_reg);
    assign st.scan_done    = (pos_reg >= count_reg) || (rd_deadline > d_reg);
    assign st.id_ok        = (32'(id_ext) < 32'(CAPACITY)) && in_use_reg[id_ext[SW-1:0]];
    assign st.out_busy     = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg    <= '0;
            stopped_reg   <= '0;
            count_reg     <= '0;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.alloc)
            begin
                in_use_reg[free_slot]  <= 1'b1;
                stopped_reg[free_slot] <= 1'b0;
            end
            if (cmd.mark_stop)
            begin
                stopped_reg[id_ext[SW-1:0]] <= 1'b1;
            end
            if (cmd.set_time)
            begin
                last_time_reg <= now_reg;
            end
            if (cmd.prune_head)
            begin
                in_use_reg[rd_slot]  <= 1'b0;
                stopped_reg[rd_slot] <= 1'b0;
            end
            if (cmd.prune_head || cmd.fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
            else if (cmd.place)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg    <= in_data[1:0];
            delay_reg <= in_data[33:2];
            id_reg    <= in_data[37:34];
            now_reg   <= in_data[100:38];
            pos_reg   <= '0;
        end
        else if (cmd.scan_step)
        begin
            pos_reg <= pos_reg + 1'b1;
        end
        if (cmd.alloc)
        begin
            period_reg[free_slot]   <= delay_reg;
            deadline_reg[free_slot] <= start_dl;
            slot_reg                <= free_slot;
            d_reg                   <= start_dl;
        end
        if (cmd.fire)
        begin
            deadline_reg[rd_slot] <= fire_dl;
            slot_reg              <= rd_slot;
            d_reg                 <= fire_dl;
        end
        if (cmd.prune_head || cmd.fire)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
            begin
                order_reg[i] <= order_reg[i + 1];
            end
        end
        else if (cmd.place)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (CW'(i) == pos_reg)
                begin
                    order_reg[i] <= slot_reg;
                end
                else if (i > 0 && CW'(i) > pos_reg)
                begin
                    order_reg[i] <= order_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_code;
            out_rid_reg    <= (cmd.out_code == ST_STARTED || cmd.out_code == ST_FIRED)
                              ? ID_W'(slot_reg) : '0;
            out_wait_reg   <= (cmd.out_code == ST_WAITING) ? rd_deadline - now_reg : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {2'b00, out_wait_reg, out_rid_reg, out_status_reg};

endmodule

>>> sv/periodic_timer_queue_top.sv
// Top level of the periodic timer queue: streaming ports around controller and datapath.
// A start passes through decode and then the insertion scan, which walks the entries
// due earlier or at the same time; a stop, or a start with no free slot, is answered
// from decode; a dispatch passes through decode and head pruning, which drops stopped
// head entries, and on a firing through the insertion scan as well. One word at a time:
// the next word is taken once the result has left the output register.
// Reset (rst_n, asynchronous, active low) empties the queue, frees every slot and sets
// the last seen time to zero.
module periodic_timer_queue_top
    import ptq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: operation[1:0], delay_us[33:2], timer_id[37:34],
    // time_now_us[100:38], zero fill [103:101].
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // Fields from bit 0: status[2:0], result_id[6:3], wait_us[69:7], zero fill [71:70].
    output logic [OUT_W-1:0] m_tdata
);

    cmd_t  cmd;
    stat_t st;

    // The controller sequences each word through decode and, as its operation needs, head
    // pruning and the insertion scan; the datapath holds all timer state and the result word.
    ptq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ptq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .st        (st),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
